FILE: rtl/radial_alpha_gradient_top_defines.svh
// Assertion macros shared by the radial alpha gradient RTL.
`ifndef RADIAL_ALPHA_GRADIENT_TOP_DEFINES_SVH
`define RADIAL_ALPHA_GRADIENT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RAGD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAGD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAGD_ASSERT(lbl, clk, rst, prop, msg)
`define RAGD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/ragd_pkg.sv
package ragd_pkg;

   localparam int POS_W      = 12;
   localparam int COL_W      = 8;
   localparam int DIAM_W     = 13;
   localparam int TR_W       = 9;
   localparam int RAD_W      = DIAM_W - 1;
   localparam int FRAC_W     = 8;
   localparam int RQ_W       = RAD_W + FRAC_W;
   localparam int IDX_W      = 3;
   localparam int DATA_W     = 13;
   localparam int SQ_W       = 2 * POS_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int RADICAND_W = SUM_W + 1;
   localparam int ROOT_W     = 21;
   localparam int REM_W      = ROOT_W + 1;
   localparam int QUO_W      = 8;
   localparam int NUM_W      = RQ_W + QUO_W;

   localparam logic [DIAM_W-1:0] DIAM_RESET = 13'd64;
   localparam logic [TR_W-1:0]   TR_FULL    = 9'd256;

   typedef enum logic [IDX_W-1:0] {
      CSR_DIAMETER     = 3'd0,
      CSR_TRANSPARENCY = 3'd1,
      CSR_FILL_RED     = 3'd2,
      CSR_FILL_GREEN   = 3'd3,
      CSR_FILL_BLUE    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [COL_W-1:0] in_red;
      logic [COL_W-1:0] in_green;
      logic [COL_W-1:0] in_blue;
      logic [COL_W-1:0] in_alpha;
   } req_beat_type;

   typedef struct packed {
      logic [COL_W-1:0] out_red;
      logic [COL_W-1:0] out_green;
      logic [COL_W-1:0] out_blue;
      logic [COL_W-1:0] out_alpha;
   } rsp_beat_type;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] data;
   } csr_beat_type;

   typedef struct packed {
      logic [RAD_W-1:0] radius;
      logic [RQ_W-1:0]  rq;
      logic [TR_W-1:0]  tscale;
      logic [COL_W-1:0] fill_red;
      logic [COL_W-1:0] fill_green;
      logic [COL_W-1:0] fill_blue;
   } cfg_type;

   typedef struct packed {
      logic         bypass;
      rsp_beat_type pix;
   } side_type;

endpackage

FILE: rtl/ragd_stream_if.sv
interface ragd_stream_if #(parameter type beat_type = logic) ();
   logic     valid;
   logic     ready;
   beat_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ragd_csr.sv
module ragd_csr #(
   parameter int MAX_SIZE = 4096
) (
   input  logic              clock,
   input  logic              reset,
   ragd_stream_if.sink       csr_if,
   output ragd_pkg::cfg_type cfg
);
   import ragd_pkg::*;

   localparam int DIAM_ALL = 2 ** DIAM_W - 1;
   localparam int DIAM_CAP = (MAX_SIZE < DIAM_ALL) ? MAX_SIZE : DIAM_ALL;
   localparam logic [DIAM_W-1:0] DIAM_LIMIT = DIAM_W'(DIAM_CAP);

   logic [DIAM_W-1:0] diameter_ff;
   logic [TR_W-1:0]   transparency_ff;
   logic [COL_W-1:0]  fill_red_ff;
   logic [COL_W-1:0]  fill_green_ff;
   logic [COL_W-1:0]  fill_blue_ff;
   logic [DIAM_W-1:0] diam_sat;
   logic [TR_W-1:0]   tr_sat;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff     <= DIAM_RESET;
         transparency_ff <= '0;
         fill_red_ff     <= '0;
         fill_green_ff   <= '0;
         fill_blue_ff    <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.data.index)
            CSR_DIAMETER:     diameter_ff     <= csr_if.data.data[DIAM_W-1:0];
            CSR_TRANSPARENCY: transparency_ff <= csr_if.data.data[TR_W-1:0];
            CSR_FILL_RED:     fill_red_ff     <= csr_if.data.data[COL_W-1:0];
            CSR_FILL_GREEN:   fill_green_ff   <= csr_if.data.data[COL_W-1:0];
            CSR_FILL_BLUE:    fill_blue_ff    <= csr_if.data.data[COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      diam_sat       = (diameter_ff > DIAM_LIMIT) ? DIAM_LIMIT : diameter_ff;
      tr_sat         = (transparency_ff > TR_FULL) ? TR_FULL : transparency_ff;
      cfg.radius     = diam_sat[DIAM_W-1:1];
      cfg.rq         = {diam_sat[DIAM_W-1:1], {FRAC_W{1'b0}}};
      cfg.tscale     = TR_FULL - tr_sat;
      cfg.fill_red   = fill_red_ff;
      cfg.fill_green = fill_green_ff;
      cfg.fill_blue  = fill_blue_ff;
   end

endmodule

FILE: rtl/ragd_front.sv
module ragd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  ragd_pkg::req_beat_type       in_beat,
   input  ragd_pkg::cfg_type            cfg,
   output logic                         out_valid,
   output logic [ragd_pkg::SUM_W-1:0]   out_sum,
   output ragd_pkg::side_type           out_side
);
   import ragd_pkg::*;

   logic             v1_ff, v2_ff, v3_ff;
   logic [POS_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic [SUM_W-1:0] sum_ff;
   side_type         side1_ff, side2_ff, side3_ff, side1_in;

   always_comb begin
      dx_in = (in_beat.pos_x >= cfg.radius) ? in_beat.pos_x - cfg.radius
                                             : cfg.radius - in_beat.pos_x;
      dy_in = (in_beat.pos_y >= cfg.radius) ? in_beat.pos_y - cfg.radius
                                             : cfg.radius - in_beat.pos_y;
      side1_in.bypass        = (cfg.radius == '0) ||
                               ((in_beat.in_red | in_beat.in_green | in_beat.in_blue) != '0);
      side1_in.pix.out_red   = in_beat.in_red;
      side1_in.pix.out_green = in_beat.in_green;
      side1_in.pix.out_blue  = in_beat.in_blue;
      side1_in.pix.out_alpha = in_beat.in_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         side1_ff <= side1_in;
         sqx_ff   <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
         sqy_ff   <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
         side2_ff <= side1_ff;
         sum_ff   <= SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_sum   = sum_ff;
   assign out_side  = side3_ff;

endmodule

FILE: rtl/ragd_sqrt.sv
`include "radial_alpha_gradient_top_defines.svh"
module ragd_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ragd_pkg::SUM_W-1:0]  in_sum,
   input  ragd_pkg::side_type          in_side,
   output logic                        out_valid,
   output logic [ragd_pkg::ROOT_W-1:0] out_root,
   output ragd_pkg::side_type          out_side
);
   import ragd_pkg::*;

   logic                  v_ff    [ROOT_W];
   logic [REM_W-1:0]      rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]     root_ff [ROOT_W];
   logic [RADICAND_W-1:0] rad_ff  [ROOT_W];
   side_type              side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic                  v_prev;
      logic [REM_W-1:0]      rem_prev;
      logic [ROOT_W-1:0]     root_prev;
      logic [RADICAND_W-1:0] rad_prev;
      side_type              side_prev;
      logic [REM_W+1:0]      cur;
      logic [REM_W+1:0]      trial;
      logic                  ge;

      if (k == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = RADICAND_W'(in_sum);
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         cur   = {rem_prev, rad_prev[RADICAND_W-1 -: 2]};
         trial = {1'b0, root_prev, 2'b01};
         ge    = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
            root_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            rad_ff[k]  <= {rad_prev[RADICAND_W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

   `RAGD_ASSERT(a_rem_bound, clock, reset, v_ff[ROOT_W-1] |-> (rem_ff[ROOT_W-1] <= (REM_W'(root_ff[ROOT_W-1]) << 1)), "square root remainder exceeds twice the root")

endmodule

FILE: rtl/ragd_alpha.sv
`include "radial_alpha_gradient_top_defines.svh"
module ragd_alpha (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ragd_pkg::ROOT_W-1:0] in_root,
   input  ragd_pkg::side_type          in_side,
   input  ragd_pkg::cfg_type           cfg,
   output logic                        out_valid,
   output ragd_pkg::rsp_beat_type      out_beat
);
   import ragd_pkg::*;

   logic                  va_ff;
   logic [NUM_W-1:0]      num_ff, num_in;
   side_type              sidea_ff;
   logic                  in_circle;
   logic [ROOT_W-1:0]     diff;
   logic [ROOT_W-1:0]     rq_ext;

   logic                  v_ff    [QUO_W];
   logic [NUM_W-1:0]      rem_ff  [QUO_W];
   logic [QUO_W-1:0]      q_ff    [QUO_W];
   side_type              side_ff [QUO_W];

   logic [QUO_W+TR_W-1:0] prod;
   logic [COL_W-1:0]      alpha;

   always_comb begin
      rq_ext    = ROOT_W'(cfg.rq);
      in_circle = (in_root < rq_ext);
      diff      = rq_ext - in_root;
      num_in    = in_circle ? (NUM_W'(diff) << FRAC_W) - NUM_W'(diff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         sidea_ff <= in_side;
      end
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      logic             v_prev;
      logic [NUM_W-1:0] rem_prev;
      logic [QUO_W-1:0] q_prev;
      side_type         side_prev;
      logic [NUM_W-1:0] divisor;
      logic             ge;

      if (k == 0) begin : g_first
         assign v_prev    = va_ff;
         assign rem_prev  = num_ff;
         assign q_prev    = '0;
         assign side_prev = sidea_ff;
      end else begin : g_next
         assign v_prev    = v_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         divisor = NUM_W'(cfg.rq) << (QUO_W - 1 - k);
         ge      = (rem_prev >= divisor);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? rem_prev - divisor : rem_prev;
            q_ff[k]    <= {q_prev[QUO_W-2:0], ge};
            side_ff[k] <= side_prev;
         end
      end
   end

   always_comb begin
      prod  = (QUO_W+TR_W)'(q_ff[QUO_W-1]) * (QUO_W+TR_W)'(cfg.tscale);
      alpha = prod[FRAC_W +: COL_W];
      if (side_ff[QUO_W-1].bypass) begin
         out_beat = side_ff[QUO_W-1].pix;
      end else begin
         out_beat.out_red   = cfg.fill_red;
         out_beat.out_green = cfg.fill_green;
         out_beat.out_blue  = cfg.fill_blue;
         out_beat.out_alpha = alpha;
      end
   end

   assign out_valid = v_ff[QUO_W-1];

   `RAGD_ASSERT(a_quotient_range, clock, reset, (v_ff[QUO_W-1] && !side_ff[QUO_W-1].bypass) |-> (rem_ff[QUO_W-1] < NUM_W'(cfg.rq)), "falloff remainder out of range")

endmodule

FILE: rtl/radial_alpha_gradient_top.sv
// Throughput: one pixel per clock; 3 front stages, 21 square root stages,
// 1 falloff stage and 8 divider stages, all stalled together by the output register.
// Reset: synchronous, active high; clears all valid bits and loads the register defaults.
`include "radial_alpha_gradient_top_defines.svh"
module radial_alpha_gradient_top #(
   parameter int MAX_SIZE = 4096
) (
   input  logic          clock,
   input  logic          reset,
   ragd_stream_if.sink   req_if,
   ragd_stream_if.source rsp_if,
   ragd_stream_if.sink   csr_if
);
   import ragd_pkg::*;

   cfg_type           cfg;
   logic              en;
   logic              out_load;
   logic              front_valid;
   logic [SUM_W-1:0]  front_sum;
   side_type          front_side;
   logic              sqrt_valid;
   logic [ROOT_W-1:0] sqrt_root;
   side_type          sqrt_side;
   logic              alpha_valid;
   rsp_beat_type      alpha_beat;
   logic              out_v_ff;
   rsp_beat_type      out_beat_ff;

   ragd_csr #(.MAX_SIZE(MAX_SIZE)) u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   ragd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .in_beat   (req_if.data),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_sum   (front_sum),
      .out_side  (front_side)
   );

   ragd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_sum    (front_sum),
      .in_side   (front_side),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   ragd_alpha u_alpha (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_root   (sqrt_root),
      .in_side   (sqrt_side),
      .cfg       (cfg),
      .out_valid (alpha_valid),
      .out_beat  (alpha_beat)
   );

   assign out_load     = !out_v_ff || rsp_if.ready;
   assign en           = !alpha_valid || out_load;
   assign req_if.ready = en;
   assign rsp_if.valid = out_v_ff;
   assign rsp_if.data  = out_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff <= alpha_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_beat_ff <= alpha_beat;
      end
   end

   `RAGD_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_if.valid, "rsp valid right after reset")
   `RAGD_ASSERT(a_ready_when_empty, clock, reset, !rsp_if.valid |-> req_if.ready, "req stalled with empty output")
   `RAGD_ASSERT(a_rsp_from_pipe, clock, reset, $rose(rsp_if.valid) |-> $past(alpha_valid), "rsp valid without a finished beat")

endmodule

FILE: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ragd_pkg::*;

   localparam int MAX_SIZE      = 4096;
   localparam int POS_MAX       = (1 << POS_W) - 1;
   localparam int RSP_W         = $bits(rsp_beat_type);
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_PIXELS  = 65;
   localparam int MAX_REPORTS   = 10;
   localparam int CORNER_ROWS   = 37;

   typedef enum bit {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      csr_index_type     idx;
      logic [DATA_W-1:0] value;
      req_beat_type      pix;
      bit                known;
      rsp_beat_type      want;
   } corner_row_type;

   typedef struct packed {
      bit           known;
      rsp_beat_type want;
   } typed_pixel_type;

   logic clock;
   logic reset;

   ragd_stream_if #(.beat_type(req_beat_type)) req_if ();
   ragd_stream_if #(.beat_type(rsp_beat_type)) rsp_if ();
   ragd_stream_if #(.beat_type(csr_beat_type)) csr_if ();

   radial_alpha_gradient_top #(.MAX_SIZE(MAX_SIZE)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   logic [DIAM_W-1:0] cfg_diameter;
   logic [TR_W-1:0]   cfg_transparency;
   logic [COL_W-1:0]  cfg_fill_red;
   logic [COL_W-1:0]  cfg_fill_green;
   logic [COL_W-1:0]  cfg_fill_blue;

   rsp_beat_type    pending_pixels [$];
   typed_pixel_type typed_pixels [$];

   int errors          = 0;
   int pixels_sent     = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int idle_cycles     = 0;
   bit idle_off        = 1'b0;

   string field_names [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

   corner_row_type corner_rows [CORNER_ROWS] = '{
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd4095, 12'd4095, 8'd1, 8'd0, 8'd0, 8'd0},
        1'b1, {8'd1, 8'd0, 8'd0, 8'd0}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd0, 12'd4095, 8'd0, 8'd128, 8'd0, 8'd77},
        1'b1, {8'd0, 8'd128, 8'd0, 8'd77}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd4095, 12'd0, 8'd0, 8'd0, 8'd1, 8'd200},
        1'b1, {8'd0, 8'd0, 8'd1, 8'd200}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd32, 12'd32, 8'd0, 8'd0, 8'd0, 8'd123},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd255}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd255},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd0}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd0}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd32, 12'd0, 8'd0, 8'd0, 8'd0, 8'd9},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd0}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd33, 12'd30, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b0, '0},
      '{ROW_CSR, CSR_FILL_RED, 13'd255, '0, 1'b0, '0},
      '{ROW_CSR, CSR_FILL_GREEN, 13'd255, '0, 1'b0, '0},
      '{ROW_CSR, CSR_FILL_BLUE, 13'd255, '0, 1'b0, '0},
      '{ROW_CSR, CSR_TRANSPARENCY, 13'd128, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd32, 12'd32, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd127}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd40, 12'd20, 8'd0, 8'd0, 8'd0, 8'd3},
        1'b0, '0},
      '{ROW_CSR, CSR_TRANSPARENCY, 13'd256, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd32, 12'd32, 8'd0, 8'd0, 8'd0, 8'd50},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd0}},
      '{ROW_CSR, CSR_TRANSPARENCY, 13'd511, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd31, 12'd33, 8'd0, 8'd0, 8'd0, 8'd50},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd0}},
      '{ROW_CSR, CSR_TRANSPARENCY, 13'd0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_DIAMETER, 13'd1, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd99},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd99}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd1, 12'd1, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd0}},
      '{ROW_CSR, CSR_DIAMETER, 13'd0, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd42},
        1'b1, {8'd0, 8'd0, 8'd0, 8'd42}},
      '{ROW_CSR, CSR_DIAMETER, 13'd2, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd1, 12'd1, 8'd0, 8'd0, 8'd0, 8'd7},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd7},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd0}},
      '{ROW_CSR, CSR_DIAMETER, 13'd8191, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd2048, 12'd2048, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd4095, 12'd2048, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd2100, 12'd1900, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b0, '0},
      '{ROW_CSR, CSR_DIAMETER, 13'd4096, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd2048, 12'd2048, 8'd0, 8'd0, 8'd0, 8'd1},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 8'd255},
        1'b1, {8'd255, 8'd255, 8'd255, 8'd255}},
      '{ROW_CSR, CSR_DIAMETER, 13'd4095, '0, 1'b0, '0},
      '{ROW_PIXEL, CSR_DIAMETER, '0, {12'd2047, 12'd2000, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b0, '0}
   };

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 23; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_beat_type falloff_pixel(req_beat_type p);
      longint unsigned radius;
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned distance_q8;
      longint unsigned rq;
      longint unsigned base;
      longint unsigned tr;
      rsp_beat_type q;
      radius = longint'(cfg_diameter);
      if (radius > MAX_SIZE) radius = 64'(MAX_SIZE);
      radius = radius / 2;
      q = '{p.in_red, p.in_green, p.in_blue, p.in_alpha};
      if (radius == 0 || {p.in_red, p.in_green, p.in_blue} != '0) return q;
      dx = (p.pos_x >= radius) ? p.pos_x - radius : radius - p.pos_x;
      dy = (p.pos_y >= radius) ? p.pos_y - radius : radius - p.pos_y;
      distance_q8 = floor_sqrt((dx * dx + dy * dy) << 16);
      rq = radius << 8;
      base = (distance_q8 < rq) ? (64'd255 * (rq - distance_q8)) / rq : 64'd0;
      tr = (cfg_transparency > 256) ? 64'd256 : longint'(cfg_transparency);
      q.out_red   = cfg_fill_red;
      q.out_green = cfg_fill_green;
      q.out_blue  = cfg_fill_blue;
      q.out_alpha = COL_W'((base * (64'd256 - tr)) >> 8);
      return q;
   endfunction

   function automatic logic [POS_W-1:0] near_centre(int radius);
      int span;
      int v;
      if ($urandom_range(0, 3) == 0) return POS_W'($urandom);
      span = radius + 2;
      v = radius + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > POS_MAX) v = POS_MAX;
      return POS_W'(v);
   endfunction

   function automatic void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   task automatic send_pixel(req_beat_type p, bit known, rsp_beat_type want);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, 12);
      typed_pixels.push_back('{known, want});
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic write_csr(csr_index_type idx, logic [DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      csr_if.valid <= 1'b1;
      csr_if.data  <= '{index: idx, data: value};
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      typed_pixel_type tag;
      rsp_beat_type want;
      bit moved;
      moved = 1'b0;
      if (reset) begin
         cfg_diameter     = DIAM_RESET;
         cfg_transparency = '0;
         cfg_fill_red     = '0;
         cfg_fill_green   = '0;
         cfg_fill_blue    = '0;
         idle_cycles     <= 0;
      end else begin
         if (csr_if.valid === 1'b1 && csr_if.ready === 1'b1) begin
            case (csr_if.data.index)
               CSR_DIAMETER:     cfg_diameter     = csr_if.data.data;
               CSR_TRANSPARENCY: cfg_transparency = csr_if.data.data[TR_W-1:0];
               CSR_FILL_RED:     cfg_fill_red     = csr_if.data.data[COL_W-1:0];
               CSR_FILL_GREEN:   cfg_fill_green   = csr_if.data.data[COL_W-1:0];
               CSR_FILL_BLUE:    cfg_fill_blue    = csr_if.data.data[COL_W-1:0];
               default: ;
            endcase
            csr_writes++;
            moved = 1'b1;
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            tag = typed_pixels.pop_front();
            pending_pixels.push_back(tag.known ? tag.want : falloff_pixel(req_if.data));
            pixels_sent++;
            moved = 1'b1;
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
               note_error($sformatf("result %h with nothing expected", rsp_if.data));
            end else begin
               want = pending_pixels.pop_front();
               for (int f = 0; f < 4; f++) begin
                  if (rsp_if.data[RSP_W-1-COL_W*f -: COL_W] !== want[RSP_W-1-COL_W*f -: COL_W])
                     note_error($sformatf("%s of result %0d: expected %0d, got %0d",
                        field_names[f], results_checked,
                        want[RSP_W-1-COL_W*f -: COL_W],
                        rsp_if.data[RSP_W-1-COL_W*f -: COL_W]));
               end
               results_checked++;
            end
            moved = 1'b1;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_off ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   initial begin
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("** radial_alpha_gradient_top: FAILED **");
      $finish;
   end

   initial begin
      corner_row_type row;
      req_beat_type p;
      int diam;
      int tr;
      int radius;
      logic [COL_W-1:0] fr;
      logic [COL_W-1:0] fg;
      logic [COL_W-1:0] fb;

      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_rows[i]) begin
         row = corner_rows[i];
         if (row.kind == ROW_CSR) write_csr(row.idx, row.value);
         else send_pixel(row.pix, row.known, row.want);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         diam = int'($urandom_range(2, MAX_SIZE));
         tr   = int'($urandom_range(0, 300));
         fr   = COL_W'($urandom);
         fg   = COL_W'($urandom);
         fb   = COL_W'($urandom);
         case (ph)
            0: begin
               diam = MAX_SIZE;
               tr   = 0;
               fr   = '1;
               fg   = '1;
               fb   = '1;
            end
            1: begin
               diam = (1 << DIAM_W) - 1;
               tr   = (1 << TR_W) - 1;
               fr   = '0;
               fg   = '0;
               fb   = '0;
            end
            2: diam = 1;
            3: diam = 0;
            4: begin
               diam = 2;
               tr   = int'(TR_FULL);
            end
            5: begin
               diam = 3;
               tr   = 1;
            end
            6: begin
               diam = 64;
               tr   = 255;
            end
            default: ;
         endcase
         idle_off = (ph % 4 == 3);
         write_csr(CSR_DIAMETER, DATA_W'(diam));
         write_csr(CSR_TRANSPARENCY, DATA_W'(tr));
         write_csr(CSR_FILL_RED, DATA_W'(fr));
         write_csr(CSR_FILL_GREEN, DATA_W'(fg));
         write_csr(CSR_FILL_BLUE, DATA_W'(fb));
         radius = ((diam > MAX_SIZE) ? MAX_SIZE : diam) / 2;

         for (int n = 0; n < PHASE_PIXELS; n++) begin
            p.pos_x    = near_centre(radius);
            p.pos_y    = near_centre(radius);
            p.in_alpha = COL_W'($urandom);
            if ($urandom_range(0, 9) < 7) begin
               {p.in_red, p.in_green, p.in_blue} = '0;
            end else if ($urandom_range(0, 2) == 0) begin
               p.in_red   = '0;
               p.in_green = '0;
               p.in_blue  = COL_W'($urandom_range(1, 255));
            end else begin
               {p.in_red, p.in_green, p.in_blue} = (3 * COL_W)'($urandom);
            end
            send_pixel(p, 1'b0, '0);
         end
      end
      idle_off = 1'b0;

      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0)
         note_error($sformatf("%0d results never arrived", pending_pixels.size()));

      $display("Sent %0d pixels, checked %0d results against the radial falloff predictor",
         pixels_sent, results_checked);
      $display("Made %0d register writes: diameters 0 to 8191, transparency 0 to 511",
         csr_writes);
      if (errors == 0) begin
         $display("** radial_alpha_gradient_top: PASSED **");
      end else begin
         $display("%0d mismatches", errors);
         $display("** radial_alpha_gradient_top: FAILED **");
      end
      $finish;
   end

endmodule
